// ===== src/fsha1_pkg.sv =====
// Shared types, constants and round functions for the flawed SHA-1 block hasher.
// Depends on nothing; every other file of the block imports it.
`timescale 1ns / 1ps

package fsha1_pkg;

	localparam int NUM_WORDS    = 16;
	localparam int NUM_ROUNDS   = 80;
	localparam int DIGEST_WORDS = 5;
	localparam int QUEUE_DEPTH  = 4;

	localparam int WCNT_W  = $clog2(NUM_WORDS);
	localparam int ROUND_W = $clog2(NUM_ROUNDS);
	localparam int IDX_W   = 3;
	localparam int QPTR_W  = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W  = $clog2(QUEUE_DEPTH + 1);

	// Operation codes on the op input.
	localparam logic [1:0] OP_CLEAR  = 2'd0;
	localparam logic [1:0] OP_INIT   = 2'd1;
	localparam logic [1:0] OP_WORD   = 2'd2;
	localparam logic [1:0] OP_UNUSED = 2'd3;

	localparam logic [31:0] IV [DIGEST_WORDS] = '{
		32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
	};

	localparam logic [31:0] K0 = 32'h5A827999;
	localparam logic [31:0] K1 = 32'h6ED9EBA1;
	localparam logic [31:0] K2 = 32'h8F1BBCDC;
	localparam logic [31:0] K3 = 32'hCA62C1D6;

	typedef enum logic [1:0] {
		CMD_CLEAR,
		CMD_INIT,
		CMD_WORD
	} cmd_kind_t;

	// One classified request as it travels from the front end to the engine.
	typedef struct packed {
		cmd_kind_t   kind;
		logic [31:0] word;
		logic        emit;
		logic        blk_end;
	} cmd_t;

	typedef struct packed {
		logic empty;
		logic full;
	} q_status_t;

	function automatic logic [31:0] rotl5(input logic [31:0] x);
		rotl5 = {x[26:0], x[31:27]};
	endfunction

	function automatic logic [31:0] rotl30(input logic [31:0] x);
		rotl30 = {x[1:0], x[31:2]};
	endfunction

	// Rotate by 30 where the two bits entering at the top are also forced
	// high when the sign bit of the operand is set.
	function automatic logic [31:0] rotl30_sign(input logic [31:0] x);
		rotl30_sign = {x[1:0] | {2{x[31]}}, x[31:2]};
	endfunction

	function automatic logic [31:0] round_f(input logic [1:0] stage,
			input logic [31:0] b, input logic [31:0] c, input logic [31:0] d);
		case (stage)
			2'd0: round_f = (b & c) | (~b & d);
			2'd2: round_f = (b & c) | (b & d) | (c & d);
			default: round_f = b ^ c ^ d;
		endcase
	endfunction

	function automatic logic [31:0] round_k(input logic [1:0] stage);
		case (stage)
			2'd0: round_k = K0;
			2'd1: round_k = K1;
			2'd2: round_k = K2;
			default: round_k = K3;
		endcase
	endfunction

endpackage

// ===== src/flawed_sha1_block_hasher.sv =====
// Top level of the flawed SHA-1 block hasher: front end, command queue and
// compression engine. Depends on fsha1_pkg, fsha1_front, fsha1_queue, fsha1_engine.
//
// Channel    Direction  Handshake                   Payload
// request    in         start & !busy               op, data_word, emit_digest
// digest     out        strobe, one cycle, no stall  digest_word, word_index, last
//
// The sixteenth word starts a block: the 80 rounds run on the single round unit,
// the result is added into the chaining words, then five digest words go out if
// emission was requested. A four-entry command queue takes requests while the
// engine runs rounds; busy is high while it is full.
// Reset (arst_n low) zeroes the chaining words, the word count and the queue.
// Digest words cannot be held off; each is valid only in its strobe cycle.
`timescale 1ns / 1ps

module flawed_sha1_block_hasher import fsha1_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  op,
	input  logic [31:0] data_word,
	input  logic        emit_digest,
	output logic        strobe,
	output logic [31:0] digest_word,
	output logic [2:0]  word_index,
	output logic        last
);

	// Classified requests from the front end enter the queue here.
	logic      push;
	cmd_t      push_cmd;
	// The engine pops from the queue head when it is idle.
	logic      pop;
	cmd_t      head;
	q_status_t status;

	// The queue's full flag is the request channel's back pressure.
	assign busy = status.full;

	fsha1_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.op          (op),
		.data_word   (data_word),
		.emit_digest (emit_digest),
		.push        (push),
		.cmd         (push_cmd)
	);

	fsha1_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.head     (head),
		.status   (status)
	);

	// The engine keeps the chaining words and the message window and
	// drives the digest outputs straight from its registers.
	fsha1_engine u_engine (
		.clk         (clk),
		.arst_n      (arst_n),
		.head        (head),
		.status      (status),
		.pop         (pop),
		.strobe      (strobe),
		.digest_word (digest_word),
		.word_index  (word_index),
		.last        (last)
	);

endmodule

// ===== src/fsha1_front.sv =====
// Front end: takes requests, counts collected message words and classifies
// each request into a command for the queue. Depends on fsha1_pkg.
`timescale 1ns / 1ps

module fsha1_front import fsha1_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        busy,
	input  logic [1:0]  op,
	input  logic [31:0] data_word,
	input  logic        emit_digest,
	output logic        push,
	output cmd_t        cmd
);

	logic              accept;
	logic [WCNT_W-1:0] word_cnt_q;

	assign accept = start & ~busy;

	always_comb begin
		cmd.word    = data_word;
		cmd.emit    = emit_digest;
		cmd.blk_end = (op == OP_WORD) && (word_cnt_q == WCNT_W'(NUM_WORDS - 1));
		case (op)
			OP_CLEAR: begin
				cmd.kind = CMD_CLEAR;
				push     = accept;
			end
			OP_INIT: begin
				cmd.kind = CMD_INIT;
				push     = accept;
			end
			OP_WORD: begin
				cmd.kind = CMD_WORD;
				push     = accept;
			end
			default: begin
				// The unused code changes nothing and is dropped here.
				cmd.kind = CMD_WORD;
				push     = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			word_cnt_q <= '0;
		end else if (accept) begin
			case (op)
				OP_CLEAR, OP_INIT: word_cnt_q <= '0;
				OP_WORD: word_cnt_q <= word_cnt_q + WCNT_W'(1);
				default: word_cnt_q <= word_cnt_q;
			endcase
		end
	end

endmodule

// ===== src/fsha1_queue.sv =====
// Short command queue between the front end and the compression engine.
// Depends on fsha1_pkg for the command type and the queue depth.
`timescale 1ns / 1ps

module fsha1_queue import fsha1_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  cmd_t      push_cmd,
	input  logic      pop,
	output cmd_t      head,
	output q_status_t status
);

	cmd_t              slots_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              do_push;
	logic              do_pop;

	assign status.empty = (count_q == '0);
	assign status.full  = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign do_push      = push & ~status.full;
	assign do_pop       = pop & ~status.empty;
	assign head         = slots_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			slots_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			case ({do_push, do_pop})
				2'b10: count_q <= count_q + QCNT_W'(1);
				2'b01: count_q <= count_q - QCNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== src/fsha1_engine.sv =====
// Compression engine: executes queued commands, runs one round per cycle
// and drives the digest words out. Depends on fsha1_pkg.
`timescale 1ns / 1ps

module fsha1_engine import fsha1_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  cmd_t             head,
	input  q_status_t        status,
	output logic             pop,
	output logic             strobe,
	output logic [31:0]      digest_word,
	output logic [IDX_W-1:0] word_index,
	output logic             last
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ROUND,
		ST_ADD,
		ST_EMIT
	} state_t;

	state_t             state_q;
	logic [ROUND_W-1:0] rnd_q;
	logic [IDX_W-1:0]   idx_q;
	logic               emit_q;
	logic [31:0]        cv_q [DIGEST_WORDS];
	logic [31:0]        w_q [NUM_WORDS];
	logic [31:0]        a_q, b_q, c_q, d_q, e_q;

	logic [1:0]  stage;
	logic [31:0] t_new;
	logic [31:0] c_new;
	logic [31:0] w_next;
	logic        take_word;
	logic        start_blk;

	assign pop       = (state_q == ST_IDLE) && !status.empty;
	assign take_word = pop && (head.kind == CMD_WORD);
	assign start_blk = take_word && head.blk_end;

	always_comb begin
		if (rnd_q < ROUND_W'(20)) begin
			stage = 2'd0;
		end else if (rnd_q < ROUND_W'(40)) begin
			stage = 2'd1;
		end else if (rnd_q < ROUND_W'(60)) begin
			stage = 2'd2;
		end else begin
			stage = 2'd3;
		end
		t_new  = rotl5(a_q) + round_f(stage, b_q, c_q, d_q) + e_q + w_q[0] + round_k(stage);
		c_new  = (stage == 2'd0) ? rotl30_sign(b_q) : rotl30(b_q);
		w_next = w_q[0] ^ w_q[2] ^ w_q[8] ^ w_q[13];
	end

	// Message window: words shift in during collection, the schedule shifts
	// in during rounds, so w_q[0] is always the current round's word.
	always_ff @(posedge clk) begin
		if (take_word || state_q == ST_ROUND) begin
			for (int i = 0; i < NUM_WORDS - 1; i++) begin
				w_q[i] <= w_q[i + 1];
			end
			w_q[NUM_WORDS - 1] <= take_word ? head.word : w_next;
		end
		if (start_blk) begin
			a_q <= cv_q[0];
			b_q <= cv_q[1];
			c_q <= cv_q[2];
			d_q <= cv_q[3];
			e_q <= cv_q[4];
		end else if (state_q == ST_ROUND) begin
			a_q <= t_new;
			b_q <= a_q;
			c_q <= c_new;
			d_q <= c_q;
			e_q <= d_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rnd_q       <= '0;
			idx_q       <= '0;
			emit_q      <= 1'b0;
			strobe      <= 1'b0;
			digest_word <= '0;
			word_index  <= '0;
			last        <= 1'b0;
			for (int i = 0; i < DIGEST_WORDS; i++) begin
				cv_q[i] <= '0;
			end
		end else begin
			// The strobe and the last flag are high only in the cycle that
			// carries a digest word.
			strobe <= (state_q == ST_EMIT);
			last   <= (state_q == ST_EMIT) && (idx_q == IDX_W'(DIGEST_WORDS - 1));
			case (state_q)
				ST_IDLE: begin
					if (pop) begin
						case (head.kind)
							CMD_CLEAR: begin
								for (int i = 0; i < DIGEST_WORDS; i++) begin
									cv_q[i] <= '0;
								end
							end
							CMD_INIT: begin
								for (int i = 0; i < DIGEST_WORDS; i++) begin
									cv_q[i] <= IV[i];
								end
							end
							default: begin
								if (head.blk_end) begin
									rnd_q   <= '0;
									emit_q  <= head.emit;
									state_q <= ST_ROUND;
								end
							end
						endcase
					end
				end
				ST_ROUND: begin
					rnd_q <= rnd_q + ROUND_W'(1);
					if (rnd_q == ROUND_W'(NUM_ROUNDS - 1)) begin
						state_q <= ST_ADD;
					end
				end
				ST_ADD: begin
					cv_q[0] <= cv_q[0] + a_q;
					cv_q[1] <= cv_q[1] + b_q;
					cv_q[2] <= cv_q[2] + c_q;
					cv_q[3] <= cv_q[3] + d_q;
					cv_q[4] <= cv_q[4] + e_q;
					idx_q   <= '0;
					state_q <= emit_q ? ST_EMIT : ST_IDLE;
				end
				ST_EMIT: begin
					digest_word <= cv_q[idx_q];
					word_index  <= idx_q;
					idx_q       <= idx_q + IDX_W'(1);
					if (idx_q == IDX_W'(DIGEST_WORDS - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== src/fsha1_checker.sv =====
// Port-level checks on the digest sequence of the flawed SHA-1 block hasher,
// bound to the top level. Depends on fsha1_pkg.
`timescale 1ns / 1ps

module fsha1_checker import fsha1_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	input logic       strobe,
	input logic [2:0] word_index,
	input logic       last
);

	a_index_range: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> word_index <= 3'(DIGEST_WORDS - 1))
		else $error("digest word index out of range");

	a_last_on_final: assert property (@(posedge clk) disable iff (!arst_n)
		last |-> strobe && word_index == 3'(DIGEST_WORDS - 1))
		else $error("last flag away from the final digest word");

	a_first_index: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(strobe) |-> word_index == 3'd0)
		else $error("digest run does not start at word zero");

	a_run_continues: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !last |=> strobe && word_index == $past(word_index) + 3'd1)
		else $error("digest run broken or out of order");

	a_run_ends: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && last |=> !strobe)
		else $error("digest word after the final one");

endmodule

bind flawed_sha1_block_hasher fsha1_checker u_chk (
	.clk        (clk),
	.arst_n     (arst_n),
	.strobe     (strobe),
	.word_index (word_index),
	.last       (last)
);
